// ----- design/positional_list_store_core_defines.svh -----
// assertion macros shared by the positional list store design
// expects clk and rst_n in the scope of each use
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// same-cycle implication
`define PLSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/plsc_pkg.sv -----
// types and constants for the positional list store
// no dependencies
package plsc_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int GRP     = 8;
    localparam int NGRP    = DEPTH / GRP;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    typedef struct packed {
        logic                     en;
        logic [1:0]               act;
        logic [IDX_W-1:0]         pidx;
        logic signed [WORD_W-1:0] value;
    } plsc_ctrl_t;

endpackage

// ----- design/plsc_cell.sv -----
// one list cell: holds one word, shifts to or from its neighbors
// depends on plsc_pkg
module plsc_cell (
    input  logic                             clk,
    input  plsc_pkg::plsc_ctrl_t             ctrl,
    input  logic [plsc_pkg::IDX_W-1:0]       idx,
    input  logic signed [plsc_pkg::WORD_W-1:0] left_data,
    input  logic signed [plsc_pkg::WORD_W-1:0] right_data,
    output logic signed [plsc_pkg::WORD_W-1:0] data,
    output logic signed [plsc_pkg::WORD_W-1:0] rd_word
);
    import plsc_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     sel;
    logic                     above;

    assign sel   = (idx == ctrl.pidx);
    assign above = (idx > ctrl.pidx);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.en)
        begin
            unique case (ctrl.act)
                ACT_READ:
                begin
                    data_next = data_reg;
                end
                ACT_WRITE:
                begin
                    if (sel)
                    begin
                        data_next = ctrl.value;
                    end
                end
                ACT_INSERT:
                begin
                    if (sel)
                    begin
                        data_next = ctrl.value;
                    end
                    else if (above)
                    begin
                        data_next = left_data;
                    end
                end
                ACT_REMOVE:
                begin
                    if (sel || above)
                    begin
                        data_next = right_data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_word = (ctrl.en && ctrl.act == ACT_READ && sel) ? data_reg : '0;

endmodule

// ----- design/positional_list_store_core.sv -----
// top level of the positional list store: control, cell row, read tree
// depends on plsc_pkg, plsc_cell and positional_list_store_core_defines.svh
//
// usage
// - s_* carries one request beat: action, 1-based position, value
// - m_* returns one result beat per request: ok, read word, new length
// - actions: read, overwrite, insert (later words move up), remove
//   (later words move down); bad positions and insert into a full store
//   give ok low and leave the list untouched
// - the list is a row of 64 cells; every cell compares its index with the
//   position and loads, shifts or holds in the accept cycle
// - a result is registered in the read tree stage at the accepting edge
//   and moves on to the output register once that register is free
// - the pending read tree stage drops s_tready until its beat moves on,
//   so a new request is not taken before the last one leaves that stage
// - a result waiting in the output register does not block the next
//   request; one more result may wait in the read tree stage
// - a stalled m_tready holds both result stages and then s_tready
// - reset empties the list; cell contents are not cleared
module positional_list_store_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // action[1:0], position[8:2], value[40:9], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // ok[0], read_value[32:1], length[39:33]
);
    import plsc_pkg::*;

    `include "positional_list_store_core_defines.svh"

    logic [1:0]               in_act;
    logic [POS_W-1:0]         in_pos;
    logic signed [WORD_W-1:0] in_val;
    logic                     s_acc;

    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     ok;
    logic                     in_list;
    logic                     ins_ok;
    logic [CNT_W:0]           cnt_ext;
    logic [CNT_W:0]           pos_ext;

    plsc_ctrl_t               ctrl;

    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] cell_rd   [DEPTH];
    logic signed [WORD_W-1:0] grp_or    [NGRP];
    logic signed [WORD_W-1:0] grp_reg   [NGRP];
    logic signed [WORD_W-1:0] rd_all;

    logic                     pend_reg;
    logic                     pend_ok_reg;
    logic [CNT_W-1:0]         pend_len_reg;
    logic                     out_valid_reg;
    logic                     out_ok_reg;
    logic signed [WORD_W-1:0] out_rd_reg;
    logic [CNT_W-1:0]         out_len_reg;
    logic                     out_free;

    assign in_act = s_tdata[1:0];
    assign in_pos = s_tdata[8:2];
    assign in_val = s_tdata[40:9];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !pend_reg;
    assign s_acc    = s_tvalid && s_tready;

    // request checks
    assign cnt_ext = {1'b0, cnt_reg};
    assign pos_ext = (CNT_W + 1)'(in_pos);
    assign in_list = (in_pos != '0) && (pos_ext <= cnt_ext);
    assign ins_ok  = (in_pos != '0) && (pos_ext <= cnt_ext + 1'b1)
                     && (cnt_ext < (CNT_W + 1)'(DEPTH));

    always_comb
    begin
        ok       = 1'b0;
        cnt_next = cnt_reg;
        unique case (in_act)
            ACT_READ:
            begin
                ok = in_list;
            end
            ACT_WRITE:
            begin
                ok = in_list;
            end
            ACT_INSERT:
            begin
                ok = ins_ok;
                if (ins_ok)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                ok = in_list;
                if (in_list)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        endcase
    end

    assign ctrl.en    = s_acc && ok;
    assign ctrl.act   = in_act;
    assign ctrl.pidx  = IDX_W'(in_pos - 1'b1);
    assign ctrl.value = in_val;

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        plsc_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_word    (cell_rd[i])
        );
    end

    // read tree, first level
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_or[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                grp_or[g] = grp_or[g] | cell_rd[g*GRP + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_reg[g] <= grp_or[g];
            end
            pend_ok_reg  <= ok;
            pend_len_reg <= cnt_next;
        end
    end

    // read tree, second level
    always_comb
    begin
        rd_all = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            rd_all = rd_all | grp_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= s_acc ? cnt_next : cnt_reg;
            if (s_acc)
            begin
                pend_reg <= 1'b1;
            end
            else if (pend_reg && out_free)
            begin
                pend_reg <= 1'b0;
            end
            if (pend_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && out_free)
        begin
            out_ok_reg  <= pend_ok_reg;
            out_rd_reg  <= rd_all;
            out_len_reg <= pend_len_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_rd_reg, out_ok_reg};

    `PLSC_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_reg <= CNT_W'(DEPTH), "length above depth")
    `PLSC_ASSERT_NEXT(a_ins_grow, s_acc && ctrl.en && in_act == ACT_INSERT,
        cnt_reg == $past(cnt_reg) + 1'b1, "insert did not grow list")
    `PLSC_ASSERT_NEXT(a_rem_shrink, s_acc && ctrl.en && in_act == ACT_REMOVE,
        cnt_reg == $past(cnt_reg) - 1'b1, "remove did not shrink list")
    `PLSC_ASSERT_NEXT(a_fail_hold, s_acc && !ok, $stable(cnt_reg), "failed beat changed length")
    `PLSC_ASSERT_NEXT(a_pend_drain, pend_reg && out_free, m_tvalid, "pending result lost")

endmodule

// ----- tb/positional_list_store_core_test.sv -----
// testbench for positional_list_store_core: directed and random list actions
// checked beat by beat against a shadow list kept inside the testbench
// depends on plsc_pkg and the design files
`timescale 1ns / 1ps

module positional_list_store_core_test;
    import plsc_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         pos;
        logic [1:0]               act;
    } list_request_t;

    typedef struct packed {
        logic [6:0]               length;
        logic signed [WORD_W-1:0] read_value;
        logic                     ok;
    } list_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    list_request_t pending_reqs[$];
    list_answer_t  expected_answers[$];

    logic [WORD_W-1:0] shadow_words[DEPTH];
    int shadow_len = 0;
    int plan_len = 0;
    int beats_in = 0;
    int beats_out = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    int errors = 0;

    positional_list_store_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_answer_t apply_action(list_request_t r);
        list_answer_t res;
        int p;
        int k;
        res = '0;
        p = r.pos;
        case (r.act)
            ACT_READ:
                if (p >= 1 && p <= shadow_len)
                begin
                    res.ok = 1'b1;
                    res.read_value = shadow_words[p-1];
                end
            ACT_WRITE:
                if (p >= 1 && p <= shadow_len)
                begin
                    res.ok = 1'b1;
                    shadow_words[p-1] = r.value;
                end
            ACT_INSERT:
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < DEPTH)
                begin
                    for (k = shadow_len; k > p - 1; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[p-1] = r.value;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            default:
                if (p >= 1 && p <= shadow_len)
                begin
                    for (k = p - 1; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                    res.ok = 1'b1;
                end
        endcase
        res.length = shadow_len[6:0];
        return res;
    endfunction

    // planned length only, so random positions can aim inside the list
    function automatic void queue_action(logic [1:0] act, int pos, logic [31:0] val);
        list_request_t r;
        r.act = act;
        r.pos = pos[POS_W-1:0];
        r.value = val;
        pending_reqs.push_back(r);
        if (act == ACT_INSERT && pos >= 1 && pos <= plan_len + 1 && plan_len < DEPTH)
            plan_len++;
        else if (act == ACT_REMOVE && pos >= 1 && pos <= plan_len)
            plan_len--;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_answers.push_back(apply_action(list_request_t'(s_tdata[40:0])));
                beats_in <= beats_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() > 0 && (hold_left > 0 ||
                    $urandom_range(0, 99) >= (beats_in < 350 ? 37 : beats_in < 700 ? 74 : 0)))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'b0, pending_reqs.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && beats_out >= 150)
        begin
            m_tready <= 1'b0;
            hold_left <= 60;
            hold_done <= 1'b1;
        end
        else
            m_tready <= $urandom_range(0, 99) >=
                        (beats_out < 350 ? 74 : beats_out < 700 ? 37 : 0);
    end

    // result check
    always @(posedge clk)
    begin
        list_answer_t got;
        list_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = list_answer_t'(m_tdata);
            beats_out <= beats_out + 1;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.ok !== want.ok)
                begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
                    errors++;
                end
                if (got.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             want.read_value, got.read_value);
                    errors++;
                end
                if (got.length !== want.length)
                begin
                    $display("%0t: length expected %0d actual %0d", $time,
                             want.length, got.length);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 2000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int roll;
        int mode;
        int pos;
        logic [1:0] act;
        logic [31:0] val;

        // empty list, bad positions, extremes of value and position
        queue_action(ACT_READ, 1, 32'h0);
        queue_action(ACT_REMOVE, 1, 32'h0);
        queue_action(ACT_WRITE, 1, 32'h1234_5678);
        queue_action(ACT_INSERT, 0, 32'h1);
        queue_action(ACT_INSERT, 2, 32'h2);
        queue_action(ACT_INSERT, 1, 32'h8000_0000);
        queue_action(ACT_INSERT, 2, 32'h7fff_ffff);
        queue_action(ACT_INSERT, 1, 32'hffff_ffff);
        queue_action(ACT_INSERT, 5, 32'h5);
        queue_action(ACT_READ, 1, 32'h0);
        queue_action(ACT_READ, 2, 32'hdead_beef);
        queue_action(ACT_READ, 3, 32'h0);
        queue_action(ACT_READ, 4, 32'h0);
        queue_action(ACT_READ, 0, 32'h0);
        queue_action(ACT_WRITE, 2, 32'h0);
        queue_action(ACT_READ, 2, 32'h0);
        queue_action(ACT_REMOVE, 2, 32'h0);
        queue_action(ACT_READ, 2, 32'h0);
        queue_action(ACT_READ, 127, 32'h0);
        queue_action(ACT_INSERT, 127, 32'h7f);
        queue_action(ACT_REMOVE, 0, 32'h0);
        queue_action(ACT_WRITE, 127, 32'hffff_ffff);
        queue_action(ACT_INSERT, 3, 32'h5555_aaaa);

        // grow to full, churn, drain to empty, repeated
        for (i = 0; i < 1030; i++)
        begin
            mode = (i / 110) % 3;
            roll = $urandom_range(0, 99);
            if (mode == 0)
                act = roll < 80 ? ACT_INSERT : roll < 88 ? ACT_READ :
                      roll < 94 ? ACT_WRITE : ACT_REMOVE;
            else if (mode == 1)
                act = roll[1:0];
            else
                act = roll < 70 ? ACT_REMOVE : roll < 82 ? ACT_READ :
                      roll < 92 ? ACT_WRITE : ACT_INSERT;
            if ($urandom_range(0, 99) < 12)
                pos = $urandom_range(0, 127);
            else if (act == ACT_INSERT)
                pos = $urandom_range(1, plan_len + 1);
            else if (plan_len == 0)
                pos = $urandom_range(0, 127);
            else
                pos = $urandom_range(1, plan_len);
            roll = $urandom_range(0, 99);
            val = roll < 3 ? 32'h8000_0000 : roll < 6 ? 32'h7fff_ffff :
                  roll < 8 ? 32'h0 : roll < 10 ? 32'hffff_ffff : $urandom();
            queue_action(act, pos, val);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_answers.size() > 0)
        begin
            $display("%0t: %0d beats missing, expected %h, actual none", $time,
                     expected_answers.size(), expected_answers[0]);
            errors++;
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/plsc_pkg.sv
design/plsc_cell.sv
design/positional_list_store_core.sv
tb/positional_list_store_core_test.sv
